[hw/rtl/lsms_pkg.sv]
// Shared widths, request codes and status codes for the LIFO stack with minimum scan.
package lsms_pkg;

	// Fixed field widths.
	localparam int DATA_W = 32;
	localparam int OCC_W = 11;
	localparam int CODE_W = 2;

	// Default number of stack entries.
	localparam int DEFAULT_STACK_DEPTH = 1024;

	// Request codes carried on the input tuser.
	localparam logic [CODE_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [CODE_W-1:0] REQ_POP = 2'd1;
	localparam logic [CODE_W-1:0] REQ_MIN = 2'd2;

	// Status codes carried on the output tuser.
	localparam logic [CODE_W-1:0] ST_OK = 2'd0;
	localparam logic [CODE_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [CODE_W-1:0] ST_EMPTY = 2'd2;

	// One result item.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [OCC_W-1:0] occupancy;
		logic [CODE_W-1:0] status;
	} result_t;

endpackage

[hw/rtl/lifo_stack_with_min_scan.sv]
// LIFO stack of signed words in a synchronous memory, with push, pop and minimum scan.
//
// Requests arrive on the s_axis channel: tuser holds the request code (push, pop,
// find minimum) and tdata the word to push. One result leaves on the m_axis channel
// for every request: tdata holds the value and the occupancy after the request,
// tuser the status (ok, overflow on push, empty on pop or find minimum).
// Push, refused requests and the unused code are answered at the transfer; the result
// goes straight to the output register if that is free, and the next request can
// follow at once. Pop passes through the registered memory read and a pop state.
// Find minimum reads the N stored entries in turn, since the single read port
// delivers one stored word per cycle to the compare.
// The output register decouples the two sides: a request is taken while a result
// waits there, and if a second result completes before the first is taken it is
// parked and s_axis_tready stays low until the receiver takes the first.
// Reset clears the occupancy, the state machine and the output valid. The memory
// needs no clearing, as only entries below the occupancy are ever used.
module lifo_stack_with_min_scan
	import lsms_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// Bits from low up: push_value[31:0].
	input  logic [DATA_W-1:0]   s_axis_tdata,
	// Bits from low up: req_type[1:0].
	input  logic [CODE_W-1:0]   s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// Bits from low up: result_value[31:0], occupancy[42:32], zero fill[47:43].
	output logic [47:0]         m_axis_tdata,
	// Bits from low up: status[1:0].
	output logic [CODE_W-1:0]   m_axis_tuser
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] nxt_q, nxt_d;
	logic signed [DATA_W-1:0] min_q, min_d;
	logic signed [DATA_W-1:0] cand;
	logic [CW-1:0] cnt_inc, cnt_dec;

	logic [DATA_W-1:0] entry_store_q [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic mem_we;
	logic [AW-1:0] rd_addr;

	result_t res, pend_q, pend_d, out_q, out_d;
	logic res_vld, out_free, out_load, out_valid_q, in_xfer;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cnt_inc = cnt_q + CW'(1);
	assign cnt_dec = cnt_q - CW'(1);

	// Running minimum candidate: the first word of a scan is taken as it is.
	assign cand = ((nxt_q == CW'(1)) || ($signed(rd_data_q) < min_q)) ?
		$signed(rd_data_q) : min_q;

	// Request sequencing, memory addressing and result formation.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		nxt_d = nxt_q;
		min_d = min_q;
		mem_we = 1'b0;
		rd_addr = '0;
		res = '0;
		res_vld = 1'b0;
		pend_d = pend_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					unique case (s_axis_tuser)
						REQ_PUSH: begin
							res_vld = 1'b1;
							if (cnt_q >= DEPTH_C) begin
								res.status = ST_OVERFLOW;
								res.occupancy = OCC_W'(cnt_q);
							end else begin
								mem_we = 1'b1;
								cnt_d = cnt_inc;
								res.status = ST_OK;
								res.occupancy = OCC_W'(cnt_inc);
							end
						end
						REQ_POP: begin
							if (cnt_q == '0) begin
								res_vld = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								cnt_d = cnt_dec;
								rd_addr = cnt_dec[AW-1:0];
								state_d = S_POP;
							end
						end
						REQ_MIN: begin
							if (cnt_q == '0) begin
								res_vld = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								rd_addr = '0;
								nxt_d = CW'(1);
								state_d = S_SCAN;
							end
						end
						default: begin
							res_vld = 1'b1;
							res.status = ST_OK;
							res.occupancy = OCC_W'(cnt_q);
						end
					endcase
				end
			end
			S_POP: begin
				res_vld = 1'b1;
				res.value = $signed(rd_data_q);
				res.occupancy = OCC_W'(cnt_q);
				res.status = ST_OK;
			end
			S_SCAN: begin
				min_d = cand;
				if (nxt_q == cnt_q) begin
					res_vld = 1'b1;
					res.value = cand;
					res.occupancy = OCC_W'(cnt_q);
					res.status = ST_OK;
				end else begin
					rd_addr = nxt_q[AW-1:0];
					nxt_d = nxt_q + CW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// A finished result goes to the output register, or is parked if it is busy.
		if (res_vld) begin
			if (out_free) begin
				state_d = S_IDLE;
			end else begin
				pend_d = res;
				state_d = S_DONE;
			end
		end
	end

	assign out_load = out_free && (res_vld || (state_q == S_DONE));
	assign out_d = (state_q == S_DONE) ? pend_q : res;

	// Entry memory: one write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_store_q[cnt_q[AW-1:0]] <= s_axis_tdata;
		end
		rd_data_q <= entry_store_q[rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		nxt_q <= nxt_d;
		min_q <= min_d;
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'b0, out_q.occupancy, out_q.value};
	assign m_axis_tuser = out_q.status;

endmodule

[hw/rtl/lsms_checker.sv]
// Port-level checks for the LIFO stack with minimum scan, bound to the top level.
module lsms_checker
	import lsms_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [47:0]       m_axis_tdata,
	input logic [CODE_W-1:0] m_axis_tuser
);

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(STACK_DEPTH);

	// A stalled result holds until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// Any failed request returns a zero value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == 32'd0))
		else $error("nonzero value on failed request");

	// An empty report always comes with zero occupancy.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[42:32] == '0))
		else $error("empty status with nonzero occupancy");

	// An overflow is only reported on a full stack.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_OVERFLOW) |-> (m_axis_tdata[42:32] == FULL_OCC))
		else $error("overflow status on a stack that is not full");

endmodule

bind lifo_stack_with_min_scan lsms_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_lsms_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

[bench/tb.sv]
// Self-checking testbench for the LIFO stack with minimum scan.
module tb;
	import lsms_pkg::*;

	localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
	localparam logic [CODE_W-1:0] REQ_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 250;
	localparam int DRAIN_ITEMS = 60;
	localparam int IDLE_PERCENT = 34;
	localparam int QUIET_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 64;

	// Shadow copy of the stack that predicts each result and checks the ones that arrive.
	class stack_tracker;
		logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
		int unsigned shadow_count;
		result_t owed_results [$];
		int unsigned error_count;

		function new();
			shadow_count = 0;
			error_count = 0;
		endfunction

		// Apply one accepted request and queue the result it must produce.
		function void apply_request(logic [CODE_W-1:0] code, logic signed [DATA_W-1:0] word);
			result_t res;
			int unsigned i;
			res.value = '0;
			res.status = ST_OK;
			case (code)
				REQ_PUSH: begin
					if (shadow_count >= STACK_DEPTH) begin
						res.status = ST_OVERFLOW;
					end else begin
						shadow_words[shadow_count] = word;
						shadow_count++;
					end
				end
				REQ_POP: begin
					if (shadow_count == 0) begin
						res.status = ST_EMPTY;
					end else begin
						shadow_count--;
						res.value = shadow_words[shadow_count];
					end
				end
				REQ_MIN: begin
					if (shadow_count == 0) begin
						res.status = ST_EMPTY;
					end else begin
						res.value = shadow_words[0];
						for (i = 1; i < shadow_count; i++) begin
							if (shadow_words[i] < res.value) res.value = shadow_words[i];
						end
					end
				end
				default: begin
					// The unused code changes nothing and reports ok.
				end
			endcase
			res.occupancy = OCC_W'(shadow_count);
			owed_results.push_back(res);
		endfunction

		// Compare one result transfer with the oldest owed result.
		function void check_result(logic [47:0] data, logic [CODE_W-1:0] user);
			result_t want;
			if (owed_results.size() == 0) begin
				$error("result with nothing owed: tdata %h, tuser %0d", data, user);
				error_count++;
				return;
			end
			want = owed_results.pop_front();
			if (data[DATA_W-1:0] !== want.value) begin
				$error("result_value: expected %0d, actual %0d", want.value,
					$signed(data[DATA_W-1:0]));
				error_count++;
			end
			if (data[DATA_W+OCC_W-1:DATA_W] !== want.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", want.occupancy,
					data[DATA_W+OCC_W-1:DATA_W]);
				error_count++;
			end
			if (user !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, user);
				error_count++;
			end
		endfunction

		function int unsigned owed();
			return owed_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic steady = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic [CODE_W-1:0] s_axis_tuser = REQ_PUSH;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [CODE_W-1:0] m_axis_tuser;

	stack_tracker board = new();

	lifo_stack_with_min_scan #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver stalls at random except during steady stretches.
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Every result transfer is checked against the shadow stack.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// Send one request, with random idle cycles ahead of it, and record it once taken.
	task automatic send_request(input logic [CODE_W-1:0] code, input logic [DATA_W-1:0] word);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= code;
		s_axis_tdata <= word;
		do @(posedge clk); while (!s_axis_tready);
		board.apply_request(code, word);
	endtask

	// Mostly full-range words, with extremes and a narrow band that makes ties likely.
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1: return 32'($urandom_range(8)) - 32'd4;
			default: return $urandom();
		endcase
	endfunction

	// Random request whose mix keeps the stack shallow so that scans stay short.
	task automatic random_request();
		int unsigned r;
		int unsigned push_weight;
		r = $urandom_range(99);
		if (board.shadow_count < 12) push_weight = 50;
		else if (board.shadow_count < 40) push_weight = 36;
		else push_weight = 20;
		if (r < push_weight) send_request(REQ_PUSH, pick_word());
		else if (r < push_weight + 12) send_request(REQ_MIN, pick_word());
		else if (r < push_weight + 16) send_request(REQ_NONE, pick_word());
		else send_request(REQ_POP, pick_word());
	endtask

	// Watchdog: a long stretch without any transfer ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
			else quiet++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack, the unused code and the word extremes.
		send_request(REQ_POP, 32'h0000_0000);
		send_request(REQ_MIN, 32'hffff_ffff);
		send_request(REQ_NONE, 32'hffff_ffff);
		send_request(REQ_PUSH, 32'h7fff_ffff);
		send_request(REQ_PUSH, 32'h8000_0000);
		send_request(REQ_PUSH, 32'h0000_0000);
		send_request(REQ_PUSH, 32'hffff_ffff);
		send_request(REQ_PUSH, 32'h0000_0001);
		send_request(REQ_MIN, 32'h0000_0000);
		send_request(REQ_NONE, 32'h0000_0000);
		for (n = 0; n < 5; n++) send_request(REQ_POP, 32'h0000_0000);
		send_request(REQ_POP, 32'h0000_0000);
		send_request(REQ_MIN, 32'h0000_0000);
		send_request(REQ_PUSH, 32'h0000_0005);
		send_request(REQ_PUSH, 32'h0000_0005);
		send_request(REQ_MIN, 32'h0000_0000);
		send_request(REQ_POP, 32'h0000_0000);
		send_request(REQ_POP, 32'h0000_0000);

		// Random mix, with a stretch of back-to-back transfers in the middle.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100) steady <= 1'b1;
			if (n == 160) steady <= 1'b0;
			random_request();
		end

		// Fill to the top, then refused pushes and scans of the full stack.
		while (board.shadow_count < STACK_DEPTH) send_request(REQ_PUSH, pick_word());
		send_request(REQ_PUSH, pick_word());
		send_request(REQ_PUSH, pick_word());
		send_request(REQ_MIN, pick_word());
		send_request(REQ_POP, pick_word());
		send_request(REQ_PUSH, pick_word());
		send_request(REQ_PUSH, pick_word());
		send_request(REQ_MIN, pick_word());

		// Pop from the top without stalls, with an occasional scan on the way down.
		steady <= 1'b1;
		for (n = 1; n <= DRAIN_ITEMS; n++) begin
			send_request((n % 20 == 0) ? REQ_MIN : REQ_POP, pick_word());
		end
		steady <= 1'b0;
		s_axis_tvalid <= 1'b0;

		// Wait for every owed result, then look for stray ones.
		while (board.owed() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.error_count == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/lsms_pkg.sv
hw/rtl/lifo_stack_with_min_scan.sv
hw/rtl/lsms_checker.sv
bench/tb.sv
